FILE: hw/rtl/spws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spws_pkg
// Shared types and constants of the servo panel wave sequencer.
// ----------------------------------------------------------------------------
package spws_pkg;

  localparam int SRV_W       = 6;
  localparam int CNT_W       = 12;
  localparam int STEP_W      = 16;
  localparam int TEST_W      = 16;
  localparam int CH_BITS     = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [CNT_W-1:0]  COUNT_MAX      = 12'd4095;
  localparam logic [CNT_W-1:0]  DEFAULT_CLOSED = 12'd205;
  localparam logic [CNT_W-1:0]  DEFAULT_OPEN   = 12'd410;
  localparam logic [STEP_W-1:0] DEFAULT_STEP   = 16'd100;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_SET       = 3'd1;
  localparam logic [2:0] OP_CLOSE_ALL = 3'd2;
  localparam logic [2:0] OP_OPEN_ALL  = 3'd3;
  localparam logic [2:0] OP_WAVE      = 3'd4;
  localparam logic [2:0] OP_TEST      = 3'd5;
  localparam logic [2:0] OP_CALIB     = 3'd6;
  localparam logic [2:0] OP_QUERY     = 3'd7;

  localparam logic REG_ENABLED      = 1'b0;
  localparam logic REG_DEFAULT_STEP = 1'b1;

  typedef enum logic [2:0] {
    JOB_WRITE,
    JOB_TEST,
    JOB_WALK,
    JOB_CALIB,
    JOB_QUERY
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [SRV_W-1:0] servo;
    logic             open_flag;
    logic             in_range;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] closed_in;
    logic [CNT_W-1:0] open_in;
    logic             wave_busy;
  } job_t;

endpackage

FILE: hw/rtl/servo_panel_wave_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_panel_wave_sequencer_top
// Servo panel wave sequencer: commands in, servo writes and query replies out.
// ----------------------------------------------------------------------------
// The front end takes one command per cycle while its four-entry job queue has
// room; ticks that do not step a wave, wave starts and dropped commands are
// absorbed there in that cycle. The write engine emits one result per cycle
// when the output is taken: set, test, wave step and query give one result,
// calibration gives no result, and open all or close all give one servo write
// per servo, so the walk through the table sets the rate for those commands.
// Results pass through the job queue and the registered result stage.
module servo_panel_wave_sequencer_top #(
  parameter int SERVO_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // servo[5:0], open_flag[6], step_ms[22:7], test_count[38:23],
  // closed_in[50:39], open_in[62:51], zero[63]
  input  logic [63:0] in_tdata,
  // opcode[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // board[0], channel[4:1], pwm_count[16:5], closed_out[28:17],
  // open_out[40:29], wave_busy[41], zero[47:42]
  output logic [47:0] out_tdata,
  // is_command[0]
  output logic        out_tuser,
  output logic        out_tlast
);

  spws_pkg::job_t push_job, head_job;
  logic           push, q_full, head_valid, pop, accept;
  logic           o_board, o_busy;
  logic [3:0]     o_channel;
  logic [11:0]    o_pwm, o_closed, o_open;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  spws_front #(
    .SERVO_COUNT (SERVO_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .opcode     (in_tuser),
    .servo      (in_tdata[5:0]),
    .open_flag  (in_tdata[6]),
    .step_ms    (in_tdata[22:7]),
    .test_count (signed'(in_tdata[38:23])),
    .closed_in  (in_tdata[50:39]),
    .open_in    (in_tdata[62:51]),
    .push       (push),
    .push_job   (push_job)
  );

  spws_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  spws_back #(
    .SERVO_COUNT (SERVO_COUNT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_job       (head_job),
    .pop            (pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_is_command (out_tuser),
    .out_board      (o_board),
    .out_channel    (o_channel),
    .out_pwm_count  (o_pwm),
    .out_closed     (o_closed),
    .out_open       (o_open),
    .out_wave_busy  (o_busy),
    .out_last       (out_tlast)
  );

  assign out_tdata = {6'd0, o_busy, o_open, o_closed, o_pwm, o_channel, o_board};

endmodule

FILE: hw/rtl/spws_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spws_queue
// Short job queue between the command front end and the write engine.
// ----------------------------------------------------------------------------
module spws_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  spws_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output spws_pkg::job_t head_job
);

  spws_pkg::job_t                  slot_r [spws_pkg::QUEUE_DEPTH];
  logic [spws_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [spws_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [spws_pkg::QPTR_W:0]       count_r, count_nxt;
  logic                            do_push, do_pop;

  assign full       = (count_r == (spws_pkg::QPTR_W+1)'(spws_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("job pushed into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (spws_pkg::QPTR_W+1)'(spws_pkg::QUEUE_DEPTH))
    else $error("queue count out of bounds");

endmodule

FILE: hw/rtl/spws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spws_front
// Command front end: config registers, wave timer and command decode into jobs.
// ----------------------------------------------------------------------------
module spws_front #(
  parameter int SERVO_COUNT = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [spws_pkg::STEP_W-1:0]   cfg_wdata,
  input  logic                          accept,
  input  logic [2:0]                    opcode,
  input  logic [spws_pkg::SRV_W-1:0]    servo,
  input  logic                          open_flag,
  input  logic [spws_pkg::STEP_W-1:0]   step_ms,
  input  logic signed [spws_pkg::TEST_W-1:0] test_count,
  input  logic [spws_pkg::CNT_W-1:0]    closed_in,
  input  logic [spws_pkg::CNT_W-1:0]    open_in,
  output logic                          push,
  output spws_pkg::job_t                push_job
);

  localparam int IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SERVO_COUNT - 1);
  localparam logic [spws_pkg::SRV_W:0] SRV_LIMIT = (spws_pkg::SRV_W+1)'(SERVO_COUNT);

  logic                          enabled_r;
  logic [spws_pkg::STEP_W-1:0]   default_step_r;
  logic                          wave_active_r, wave_active_nxt;
  logic [IDX_W-1:0]              wave_index_r, wave_index_nxt;
  logic                          wave_dir_r, wave_dir_nxt;
  logic [spws_pkg::STEP_W-1:0]   wave_interval_r, wave_interval_nxt;
  logic [spws_pkg::STEP_W-1:0]   wave_wait_r, wave_wait_nxt;
  logic [spws_pkg::STEP_W-1:0]   wait_dec;
  logic                          in_range;
  logic                          wave_end;
  logic [spws_pkg::CNT_W-1:0]    test_clamped;

  assign in_range = ({1'b0, servo} < SRV_LIMIT);
  assign wait_dec = (wave_wait_r != '0) ? wave_wait_r - 1'b1 : wave_wait_r;
  assign wave_end = (wave_index_r == LAST_IDX);

  always_comb begin
    if (test_count < 0) begin
      test_clamped = '0;
    end else if (test_count > $signed({4'd0, spws_pkg::COUNT_MAX})) begin
      test_clamped = spws_pkg::COUNT_MAX;
    end else begin
      test_clamped = test_count[spws_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    wave_active_nxt   = wave_active_r;
    wave_index_nxt    = wave_index_r;
    wave_dir_nxt      = wave_dir_r;
    wave_interval_nxt = wave_interval_r;
    wave_wait_nxt     = wave_wait_r;
    push              = 1'b0;
    push_job.kind      = spws_pkg::JOB_WRITE;
    push_job.servo     = servo;
    push_job.open_flag = open_flag;
    push_job.in_range  = in_range;
    push_job.count     = test_clamped;
    push_job.closed_in = closed_in;
    push_job.open_in   = open_in;
    push_job.wave_busy = wave_active_r;
    if (accept) begin
      case (opcode)
        spws_pkg::OP_TICK: begin
          if (wave_active_r) begin
            wave_wait_nxt = wait_dec;
            if (wait_dec == '0) begin
              wave_wait_nxt      = wave_interval_r;
              wave_index_nxt     = wave_end ? '0 : wave_index_r + 1'b1;
              wave_active_nxt    = !wave_end;
              push               = enabled_r;
              push_job.servo     = spws_pkg::SRV_W'(wave_index_r);
              push_job.open_flag = wave_dir_r;
              push_job.in_range  = 1'b1;
              push_job.wave_busy = !wave_end;
            end
          end
        end
        spws_pkg::OP_SET: begin
          push = enabled_r && in_range;
        end
        spws_pkg::OP_CLOSE_ALL, spws_pkg::OP_OPEN_ALL: begin
          wave_active_nxt    = 1'b0;
          wave_index_nxt     = '0;
          push               = enabled_r;
          push_job.kind      = spws_pkg::JOB_WALK;
          push_job.open_flag = (opcode == spws_pkg::OP_OPEN_ALL);
          push_job.wave_busy = 1'b0;
        end
        spws_pkg::OP_WAVE: begin
          if (enabled_r) begin
            wave_dir_nxt      = open_flag;
            wave_interval_nxt = (step_ms != '0) ? step_ms : default_step_r;
            wave_index_nxt    = '0;
            wave_wait_nxt     = '0;
            wave_active_nxt   = 1'b1;
          end
        end
        spws_pkg::OP_TEST: begin
          push          = enabled_r && in_range;
          push_job.kind = spws_pkg::JOB_TEST;
        end
        spws_pkg::OP_CALIB: begin
          push          = in_range;
          push_job.kind = spws_pkg::JOB_CALIB;
        end
        spws_pkg::OP_QUERY: begin
          push          = 1'b1;
          push_job.kind = spws_pkg::JOB_QUERY;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r       <= 1'b0;
      default_step_r  <= spws_pkg::DEFAULT_STEP;
      wave_active_r   <= 1'b0;
      wave_index_r    <= '0;
      wave_dir_r      <= 1'b0;
      wave_interval_r <= spws_pkg::DEFAULT_STEP;
      wave_wait_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          spws_pkg::REG_ENABLED:      enabled_r      <= cfg_wdata[0];
          spws_pkg::REG_DEFAULT_STEP: default_step_r <= cfg_wdata;
          default:                    enabled_r      <= enabled_r;
        endcase
      end
      wave_active_r   <= wave_active_nxt;
      wave_index_r    <= wave_index_nxt;
      wave_dir_r      <= wave_dir_nxt;
      wave_interval_r <= wave_interval_nxt;
      wave_wait_r     <= wave_wait_nxt;
    end
  end

  a_all_cancels_wave: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (opcode == spws_pkg::OP_CLOSE_ALL || opcode == spws_pkg::OP_OPEN_ALL)
    |=> !wave_active_r)
    else $error("open or close all left wave running");

  a_idle_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !wave_active_r |-> (wave_index_r == '0))
    else $error("wave index not cleared while idle");

endmodule

FILE: hw/rtl/spws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spws_back
// Write engine: calibration table, servo walk and registered result stage.
// ----------------------------------------------------------------------------
module spws_back #(
  parameter int SERVO_COUNT = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        head_valid,
  input  spws_pkg::job_t              head_job,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_is_command,
  output logic                        out_board,
  output logic [spws_pkg::CH_BITS-1:0] out_channel,
  output logic [spws_pkg::CNT_W-1:0]  out_pwm_count,
  output logic [spws_pkg::CNT_W-1:0]  out_closed,
  output logic [spws_pkg::CNT_W-1:0]  out_open,
  output logic                        out_wave_busy,
  output logic                        out_last
);

  localparam int IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SERVO_COUNT - 1);

  logic [spws_pkg::CNT_W-1:0] closed_tab_r [SERVO_COUNT];
  logic [spws_pkg::CNT_W-1:0] open_tab_r   [SERVO_COUNT];

  logic [IDX_W-1:0]           walk_cnt_r, walk_cnt_nxt;
  logic                       out_valid_r;
  logic                       is_command_r, is_command_nxt;
  logic [spws_pkg::SRV_W-1:0] servo_r, servo_nxt;
  logic [spws_pkg::CNT_W-1:0] pwm_r, pwm_nxt;
  logic [spws_pkg::CNT_W-1:0] closed_r, closed_nxt;
  logic [spws_pkg::CNT_W-1:0] open_r, open_nxt;
  logic                       busy_r, busy_nxt;
  logic                       last_r, last_nxt;
  logic                       can_load, load, tab_we;
  logic [IDX_W-1:0]           rd_idx;
  logic                       walk_done;

  assign can_load  = !out_valid_r || out_ready;
  assign walk_done = (walk_cnt_r == LAST_IDX);
  assign rd_idx    = (head_job.kind == spws_pkg::JOB_WALK) ? walk_cnt_r
                                                           : head_job.servo[IDX_W-1:0];

  always_comb begin
    pop            = 1'b0;
    load           = 1'b0;
    tab_we         = 1'b0;
    walk_cnt_nxt   = walk_cnt_r;
    is_command_nxt = 1'b1;
    servo_nxt      = head_job.servo;
    pwm_nxt        = head_job.open_flag ? open_tab_r[rd_idx] : closed_tab_r[rd_idx];
    closed_nxt     = '0;
    open_nxt       = '0;
    busy_nxt       = head_job.wave_busy;
    last_nxt       = 1'b1;
    if (head_valid && can_load) begin
      case (head_job.kind)
        spws_pkg::JOB_WRITE: begin
          load = 1'b1;
          pop  = 1'b1;
        end
        spws_pkg::JOB_TEST: begin
          load    = 1'b1;
          pop     = 1'b1;
          pwm_nxt = head_job.count;
        end
        spws_pkg::JOB_WALK: begin
          load         = 1'b1;
          pop          = walk_done;
          servo_nxt    = spws_pkg::SRV_W'(walk_cnt_r);
          last_nxt     = walk_done;
          walk_cnt_nxt = walk_done ? '0 : walk_cnt_r + 1'b1;
        end
        spws_pkg::JOB_CALIB: begin
          tab_we = 1'b1;
          pop    = 1'b1;
        end
        spws_pkg::JOB_QUERY: begin
          load           = 1'b1;
          pop            = 1'b1;
          is_command_nxt = 1'b0;
          servo_nxt      = '0;
          pwm_nxt        = '0;
          closed_nxt     = head_job.in_range ? closed_tab_r[rd_idx] : '0;
          open_nxt       = head_job.in_range ? open_tab_r[rd_idx] : '0;
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SERVO_COUNT; i++) begin
        closed_tab_r[i] <= spws_pkg::DEFAULT_CLOSED;
        open_tab_r[i]   <= spws_pkg::DEFAULT_OPEN;
      end
    end else begin
      walk_cnt_r <= walk_cnt_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (tab_we) begin
        closed_tab_r[rd_idx] <= head_job.closed_in;
        open_tab_r[rd_idx]   <= head_job.open_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_command_r <= is_command_nxt;
      servo_r      <= servo_nxt;
      pwm_r        <= pwm_nxt;
      closed_r     <= closed_nxt;
      open_r       <= open_nxt;
      busy_r       <= busy_nxt;
      last_r       <= last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_command = is_command_r;
  assign out_board      = servo_r[spws_pkg::CH_BITS];
  assign out_channel    = servo_r[spws_pkg::CH_BITS-1:0];
  assign out_pwm_count  = pwm_r;
  assign out_closed     = closed_r;
  assign out_open       = open_r;
  assign out_wave_busy  = busy_r;
  assign out_last       = last_r;

  a_calib_silent: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid && can_load && head_job.kind == spws_pkg::JOB_CALIB |=> !out_valid_r)
    else $error("calibration produced a result");

  a_walk_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(head_valid && head_job.kind == spws_pkg::JOB_WALK) |-> (walk_cnt_r == '0))
    else $error("walk counter left running");

endmodule
